FILE: sv/mrp_pd_attitude_torque_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MRP PD attitude torque core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MRP_PD_ATTITUDE_TORQUE_CORE_ASSERT_SVH
`define MRP_PD_ATTITUDE_TORQUE_CORE_ASSERT_SVH

// same-cycle implication
`define MRPT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRPT_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define MRPT_ASSERT_DLY(name, ante, dly, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: sv/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Types, widths and register codes shared by the attitude torque core.
// ----------------------------------------------------------------------------
package mrpt_pkg;

	function automatic int imin(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// field formats
	localparam int SAMPLE_W     = 24;   // Q4.19 inputs
	localparam int ENTRY_W      = 21;   // packed inertia / known torque entry
	localparam int ROW_W        = 3 * ENTRY_W;
	localparam int GAIN_W       = 32;   // unsigned Q16.16
	localparam int TORQUE_W     = 32;   // Q12.19 output
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;

	// rescaling shifts
	localparam int INERTIA_FRAC = 8;
	localparam int CROSS_SHIFT  = 19;
	localparam int GAIN_FRAC    = 16;
	localparam int KNOWN_SHIFT  = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_ATT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KNOWN     = 3'd5;

	// intermediate widths; products wrap at 64 bits where they can exceed it
	localparam int W_W    = SAMPLE_W + 1;                        // w = dw + wr
	localparam int IWP_W  = imin(W_W + ENTRY_W, 64);
	localparam int IWS_W  = imin(IWP_W + 2, 64);
	localparam int IW_W   = IWS_W - INERTIA_FRAC;                // I*w
	localparam int C2P_W  = imin(W_W + SAMPLE_W, 64);
	localparam int C2R_W  = imin(C2P_W + 1, 64);
	localparam int C2_W   = C2R_W - CROSS_SHIFT + 1;             // w x wr
	localparam int D_W    = imax(SAMPLE_W, C2_W) + 1;            // a - c2
	localparam int IDP_W  = imin(D_W + ENTRY_W, 64);
	localparam int IDS_W  = imin(IDP_W + 2, 64);
	localparam int ID_W   = IDS_W - INERTIA_FRAC;                // I*d
	localparam int C1P_W  = imin(SAMPLE_W + IW_W, 64);
	localparam int C1R_W  = imin(C1P_W + 1, 64);
	localparam int C1_W   = C1R_W - CROSS_SHIFT + 1;             // wr x Iw
	localparam int GP_W   = imin(GAIN_W + 1 + SAMPLE_W, 64);
	localparam int GR_W   = imin(GP_W + 1, 64);
	localparam int GT_W   = GR_W - GAIN_FRAC;                    // K*sigma, P*dw
	localparam int L_W    = ENTRY_W + KNOWN_SHIFT;
	localparam int T_W    = imin(imax(imax(GT_W, C1_W), imax(ID_W, L_W)) + 4, 64);

	localparam logic signed [TORQUE_W-1:0] TORQUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [TORQUE_W-1:0] TORQUE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sigma_x;
		logic signed [SAMPLE_W-1:0] sigma_y;
		logic signed [SAMPLE_W-1:0] sigma_z;
		logic signed [SAMPLE_W-1:0] rate_err_x;
		logic signed [SAMPLE_W-1:0] rate_err_y;
		logic signed [SAMPLE_W-1:0] rate_err_z;
		logic signed [SAMPLE_W-1:0] ref_rate_x;
		logic signed [SAMPLE_W-1:0] ref_rate_y;
		logic signed [SAMPLE_W-1:0] ref_rate_z;
		logic signed [SAMPLE_W-1:0] ref_accel_x;
		logic signed [SAMPLE_W-1:0] ref_accel_y;
		logic signed [SAMPLE_W-1:0] ref_accel_z;
	} cmd_t;

	typedef struct packed {
		logic signed [TORQUE_W-1:0] torque_x;
		logic signed [TORQUE_W-1:0] torque_y;
		logic signed [TORQUE_W-1:0] torque_z;
	} res_t;

endpackage

FILE: sv/mrpt_mul.sv
// ----------------------------------------------------------------------------
// mrpt_mul
// Two-stage signed multiplier: b is split in halves, the two partial
// products are registered, then summed and truncated to P_W bits.
// ----------------------------------------------------------------------------
module mrpt_mul #(
	parameter int A_W = 21,
	parameter int B_W = 25,
	parameter int P_W = 46
) (
	input  logic                  clk,
	input  logic signed [A_W-1:0] a,
	input  logic signed [B_W-1:0] b,
	output logic signed [P_W-1:0] p
);

	localparam int BL_W   = B_W / 2;
	localparam int BH_W   = B_W - BL_W;
	localparam int FULL_W = A_W + B_W;

	logic signed [BH_W-1:0]       b_hi;
	logic        [BL_W-1:0]       b_lo;
	logic signed [A_W+BH_W-1:0]   pp_hi_c;
	logic signed [A_W+BL_W:0]     pp_lo_c;
	logic signed [A_W+BH_W-1:0]   pp_hi_s1;
	logic signed [A_W+BL_W:0]     pp_lo_s1;
	logic signed [FULL_W-1:0]     sum_c;

	// partial products: signed upper half, unsigned lower half
	always_comb begin
		b_hi    = b[B_W-1:BL_W];
		b_lo    = b[BL_W-1:0];
		pp_hi_c = (A_W+BH_W)'(a) * (A_W+BH_W)'(b_hi);
		pp_lo_c = (A_W+BL_W+1)'(a) * (A_W+BL_W+1)'($signed({1'b0, b_lo}));
	end

	always_ff @(posedge clk) begin
		pp_hi_s1 <= pp_hi_c;
		pp_lo_s1 <= pp_lo_c;
	end

	// recombine, keep the low P_W bits
	always_comb begin
		sum_c = (FULL_W'(pp_hi_s1) <<< BL_W) + FULL_W'(pp_lo_s1);
	end

	always_ff @(posedge clk) begin
		p <= P_W'(sum_c);
	end

endmodule

FILE: sv/mrpt_imul.sv
// ----------------------------------------------------------------------------
// mrpt_imul
// Inertia matrix times vector. Nine pipelined products, row sums rounded
// half up from 27 to 19 fraction bits.
// ----------------------------------------------------------------------------
module mrpt_imul #(
	parameter int V_W = 25,
	parameter int R_W = mrpt_pkg::imin(mrpt_pkg::imin(V_W + mrpt_pkg::ENTRY_W, 64) + 2, 64)
		- mrpt_pkg::INERTIA_FRAC
) (
	input  logic                                 clk,
	input  logic [2:0][mrpt_pkg::ROW_W-1:0]      rows,
	input  logic signed [V_W-1:0]                v [3],
	output logic signed [R_W-1:0]                r [3]
);

	localparam int P_W = mrpt_pkg::imin(V_W + mrpt_pkg::ENTRY_W, 64);
	localparam int S_W = mrpt_pkg::imin(P_W + 2, 64);

	logic signed [mrpt_pkg::ENTRY_W-1:0] ent  [3][3];
	logic signed [P_W-1:0]               prod [3][3];
	logic signed [S_W-1:0]               acc_c [3];

	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		for (genvar gj = 0; gj < 3; gj++) begin : g_col
			assign ent[gi][gj] =
				$signed(rows[gi][gj*mrpt_pkg::ENTRY_W +: mrpt_pkg::ENTRY_W]);

			mrpt_mul #(
				.A_W(mrpt_pkg::ENTRY_W),
				.B_W(V_W),
				.P_W(P_W)
			) u_mul (
				.clk(clk),
				.a  (ent[gi][gj]),
				.b  (v[gj]),
				.p  (prod[gi][gj])
			);
		end
	end

	// row sum plus half an LSB of the result
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = S_W'(prod[i][0]) + S_W'(prod[i][1]) + S_W'(prod[i][2])
				+ (S_W'(1) <<< (mrpt_pkg::INERTIA_FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r[i] <= R_W'(acc_c[i] >>> mrpt_pkg::INERTIA_FRAC);
		end
	end

endmodule

FILE: sv/mrpt_cross.sv
// ----------------------------------------------------------------------------
// mrpt_cross
// Cross product a x b of two Q.19 vectors. Each product is rounded half up
// to 19 fraction bits before the difference.
// ----------------------------------------------------------------------------
module mrpt_cross #(
	parameter int A_W = 25,
	parameter int B_W = 24,
	parameter int O_W = mrpt_pkg::imin(mrpt_pkg::imin(A_W + B_W, 64) + 1, 64)
		- mrpt_pkg::CROSS_SHIFT + 1
) (
	input  logic                  clk,
	input  logic signed [A_W-1:0] a [3],
	input  logic signed [B_W-1:0] b [3],
	output logic signed [O_W-1:0] r [3]
);

	localparam int P_W = mrpt_pkg::imin(A_W + B_W, 64);
	localparam int R_W = mrpt_pkg::imin(P_W + 1, 64);
	localparam int T_W = R_W - mrpt_pkg::CROSS_SHIFT;

	logic signed [P_W-1:0] prod_p [3];
	logic signed [P_W-1:0] prod_n [3];
	logic signed [R_W-1:0] rnd_p_c [3];
	logic signed [R_W-1:0] rnd_n_c [3];
	logic signed [T_W-1:0] term_p_c [3];
	logic signed [T_W-1:0] term_n_c [3];

	// component i = a[j]*b[k] - a[k]*b[j], j and k the next two axes
	for (genvar gi = 0; gi < 3; gi++) begin : g_axis
		mrpt_mul #(
			.A_W(A_W),
			.B_W(B_W),
			.P_W(P_W)
		) u_mul_p (
			.clk(clk),
			.a  (a[(gi + 1) % 3]),
			.b  (b[(gi + 2) % 3]),
			.p  (prod_p[gi])
		);

		mrpt_mul #(
			.A_W(A_W),
			.B_W(B_W),
			.P_W(P_W)
		) u_mul_n (
			.clk(clk),
			.a  (a[(gi + 2) % 3]),
			.b  (b[(gi + 1) % 3]),
			.p  (prod_n[gi])
		);
	end

	// round each product, then take the difference
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_p_c[i]  = R_W'(prod_p[i]) + (R_W'(1) <<< (mrpt_pkg::CROSS_SHIFT - 1));
			rnd_n_c[i]  = R_W'(prod_n[i]) + (R_W'(1) <<< (mrpt_pkg::CROSS_SHIFT - 1));
			term_p_c[i] = T_W'(rnd_p_c[i] >>> mrpt_pkg::CROSS_SHIFT);
			term_n_c[i] = T_W'(rnd_n_c[i] >>> mrpt_pkg::CROSS_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r[i] <= O_W'(term_p_c[i]) - O_W'(term_n_c[i]);
		end
	end

endmodule

FILE: sv/mrp_pd_attitude_torque_core.sv
// ----------------------------------------------------------------------------
// mrp_pd_attitude_torque_core
// MRP PD attitude control law with rate and acceleration feedforward.
// ----------------------------------------------------------------------------
// One command word is taken in every clock cycle: busy stays low, and the
// torque word for a command is driven on result with done high for exactly
// one cycle, once the command has passed through the nine register stages
// listed below; words leave in command order. The receiver cannot
// stall the block, so it must take each word as it comes. The nine register
// stages are the input register, I*w (three stages), d = a - w x wr, I*d
// (three stages) and the output register; wr x (I*w) and the gain products
// run alongside. Each multiply takes two stages and its rounding a third.
// Configuration writes are always ready (cfg_ready high); write
// them only while no command is in flight, since the stages read the
// registers directly. Torque is
//   T = -(K*sigma + P*dw - wr x (I*w) - I*(a - w x wr) + L),  w = dw + wr,
// with every rescale rounded half up and the result saturated to Q12.19.
// ----------------------------------------------------------------------------
`include "mrp_pd_attitude_torque_core_assert.svh"

module mrp_pd_attitude_torque_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  mrpt_pkg::cmd_t                      cmd,
	output logic                                done,
	output mrpt_pkg::res_t                      result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mrpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mrpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int SW      = mrpt_pkg::SAMPLE_W;
	localparam int EW      = mrpt_pkg::ENTRY_W;
	localparam int TW      = mrpt_pkg::T_W;
	localparam int STAGES  = 9;

	// configuration registers
	logic [mrpt_pkg::GAIN_W-1:0]         gain_att_q;
	logic [mrpt_pkg::GAIN_W-1:0]         gain_rate_q;
	logic [2:0][mrpt_pkg::ROW_W-1:0]     rows_q;
	logic [mrpt_pkg::ROW_W-1:0]          known_q;

	// valid bit of each stage, bit 0 is stage 1
	logic [STAGES-1:0]                   vld_q;

	logic                                accept;

	logic signed [SW-1:0]                sig_c [3];
	logic signed [SW-1:0]                dw_c  [3];
	logic signed [SW-1:0]                wr_c  [3];
	logic signed [SW-1:0]                acc_c [3];

	logic signed [SW-1:0]                sig_s1 [3];
	logic signed [SW-1:0]                dw_s1  [3];
	logic signed [SW-1:0]                wr_s1  [3];
	logic signed [SW-1:0]                a_s1   [3];
	logic signed [mrpt_pkg::W_W-1:0]     w_s1   [3];
	logic signed [SW-1:0]                wr_s2  [3];
	logic signed [SW-1:0]                a_s2   [3];
	logic signed [SW-1:0]                wr_s3  [3];
	logic signed [SW-1:0]                a_s3   [3];
	logic signed [SW-1:0]                wr_s4  [3];
	logic signed [SW-1:0]                a_s4   [3];

	logic signed [mrpt_pkg::GP_W-1:0]    kprod_s3 [3];
	logic signed [mrpt_pkg::GP_W-1:0]    pprod_s3 [3];
	logic signed [mrpt_pkg::GR_W-1:0]    krnd_c [3];
	logic signed [mrpt_pkg::GR_W-1:0]    prnd_c [3];
	logic signed [TW-1:0]                u_c    [3];
	logic signed [TW-1:0]                u_s4   [3];
	logic signed [TW-1:0]                u_s5   [3];
	logic signed [TW-1:0]                u_s6   [3];
	logic signed [TW-1:0]                u_s7   [3];

	logic signed [mrpt_pkg::IW_W-1:0]    iw_s4 [3];
	logic signed [mrpt_pkg::C2_W-1:0]    c2_s4 [3];
	logic signed [mrpt_pkg::D_W-1:0]     d_s5  [3];
	logic signed [mrpt_pkg::C1_W-1:0]    c1_s7 [3];
	logic signed [mrpt_pkg::ID_W-1:0]    id_s8 [3];

	logic signed [EW-1:0]                known_c [3];
	logic signed [TW-1:0]                v_c     [3];
	logic signed [TW-1:0]                v_s8    [3];
	logic signed [TW-1:0]                t_c     [3];
	logic signed [TW-1:0]                neg_c   [3];
	logic signed [mrpt_pkg::TORQUE_W-1:0] sat_c  [3];
	logic signed [mrpt_pkg::TORQUE_W-1:0] trq_s9 [3];

	// the pipeline never stalls
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_att_q  <= '0;
			gain_rate_q <= '0;
			rows_q      <= '0;
			known_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mrpt_pkg::REG_GAIN_ATT:  gain_att_q  <= cfg_data[mrpt_pkg::GAIN_W-1:0];
				mrpt_pkg::REG_GAIN_RATE: gain_rate_q <= cfg_data[mrpt_pkg::GAIN_W-1:0];
				mrpt_pkg::REG_ROW0:      rows_q[0]   <= cfg_data[mrpt_pkg::ROW_W-1:0];
				mrpt_pkg::REG_ROW1:      rows_q[1]   <= cfg_data[mrpt_pkg::ROW_W-1:0];
				mrpt_pkg::REG_ROW2:      rows_q[2]   <= cfg_data[mrpt_pkg::ROW_W-1:0];
				mrpt_pkg::REG_KNOWN:     known_q     <= cfg_data[mrpt_pkg::ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// valid bits ride along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STAGES-2:0], accept};
		end
	end

	// unpack the command word
	always_comb begin
		sig_c[0] = cmd.sigma_x;
		sig_c[1] = cmd.sigma_y;
		sig_c[2] = cmd.sigma_z;
		dw_c[0]  = cmd.rate_err_x;
		dw_c[1]  = cmd.rate_err_y;
		dw_c[2]  = cmd.rate_err_z;
		wr_c[0]  = cmd.ref_rate_x;
		wr_c[1]  = cmd.ref_rate_y;
		wr_c[2]  = cmd.ref_rate_z;
		acc_c[0] = cmd.ref_accel_x;
		acc_c[1] = cmd.ref_accel_y;
		acc_c[2] = cmd.ref_accel_z;
	end

	// stage 1: input register and body rate w = dw + wr
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				sig_s1[i] <= sig_c[i];
				dw_s1[i]  <= dw_c[i];
				wr_s1[i]  <= wr_c[i];
				a_s1[i]   <= acc_c[i];
				w_s1[i]   <= mrpt_pkg::W_W'(dw_c[i]) + mrpt_pkg::W_W'(wr_c[i]);
			end
		end
	end

	// delay lines for wr and the reference acceleration
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			wr_s2[i] <= wr_s1[i];
			wr_s3[i] <= wr_s2[i];
			wr_s4[i] <= wr_s3[i];
			a_s2[i]  <= a_s1[i];
			a_s3[i]  <= a_s2[i];
			a_s4[i]  <= a_s3[i];
		end
	end

	// gain products K*sigma and P*dw
	for (genvar gi = 0; gi < 3; gi++) begin : g_gain
		mrpt_mul #(
			.A_W(mrpt_pkg::GAIN_W + 1),
			.B_W(SW),
			.P_W(mrpt_pkg::GP_W)
		) u_kmul (
			.clk(clk),
			.a  ($signed({1'b0, gain_att_q})),
			.b  (sig_s1[gi]),
			.p  (kprod_s3[gi])
		);

		mrpt_mul #(
			.A_W(mrpt_pkg::GAIN_W + 1),
			.B_W(SW),
			.P_W(mrpt_pkg::GP_W)
		) u_pmul (
			.clk(clk),
			.a  ($signed({1'b0, gain_rate_q})),
			.b  (dw_s1[gi]),
			.p  (pprod_s3[gi])
		);
	end

	// round gain terms to 19 fraction bits and add them
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			krnd_c[i] = mrpt_pkg::GR_W'(kprod_s3[i])
				+ (mrpt_pkg::GR_W'(1) <<< (mrpt_pkg::GAIN_FRAC - 1));
			prnd_c[i] = mrpt_pkg::GR_W'(pprod_s3[i])
				+ (mrpt_pkg::GR_W'(1) <<< (mrpt_pkg::GAIN_FRAC - 1));
			u_c[i] = TW'(mrpt_pkg::GT_W'(krnd_c[i] >>> mrpt_pkg::GAIN_FRAC))
				+ TW'(mrpt_pkg::GT_W'(prnd_c[i] >>> mrpt_pkg::GAIN_FRAC));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			u_s4[i] <= u_c[i];
			u_s5[i] <= u_s4[i];
			u_s6[i] <= u_s5[i];
			u_s7[i] <= u_s6[i];
		end
	end

	// I*w, stages 2 to 4
	mrpt_imul #(
		.V_W(mrpt_pkg::W_W),
		.R_W(mrpt_pkg::IW_W)
	) u_imul_w (
		.clk (clk),
		.rows(rows_q),
		.v   (w_s1),
		.r   (iw_s4)
	);

	// w x wr, stages 2 to 4
	mrpt_cross #(
		.A_W(mrpt_pkg::W_W),
		.B_W(SW),
		.O_W(mrpt_pkg::C2_W)
	) u_cross_wwr (
		.clk(clk),
		.a  (w_s1),
		.b  (wr_s1),
		.r  (c2_s4)
	);

	// stage 5: d = a - w x wr
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s5[i] <= mrpt_pkg::D_W'(a_s4[i]) - mrpt_pkg::D_W'(c2_s4[i]);
		end
	end

	// wr x (I*w), stages 5 to 7
	mrpt_cross #(
		.A_W(SW),
		.B_W(mrpt_pkg::IW_W),
		.O_W(mrpt_pkg::C1_W)
	) u_cross_gyro (
		.clk(clk),
		.a  (wr_s4),
		.b  (iw_s4),
		.r  (c1_s7)
	);

	// I*d, stages 6 to 8
	mrpt_imul #(
		.V_W(mrpt_pkg::D_W),
		.R_W(mrpt_pkg::ID_W)
	) u_imul_d (
		.clk (clk),
		.rows(rows_q),
		.v   (d_s5),
		.r   (id_s8)
	);

	// stage 8: fold in the gyroscopic term and known torque (Q8.12 to Q.19)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			known_c[i] = $signed(known_q[i*EW +: EW]);
			v_c[i] = u_s7[i] - TW'(c1_s7[i])
				+ (TW'(known_c[i]) <<< mrpt_pkg::KNOWN_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v_s8[i] <= v_c[i];
		end
	end

	// stage 9: subtract I*d, negate, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_c[i]   = v_s8[i] - TW'(id_s8[i]);
			neg_c[i] = -t_c[i];
			if (neg_c[i] > TW'(mrpt_pkg::TORQUE_MAX)) begin
				sat_c[i] = mrpt_pkg::TORQUE_MAX;
			end else if (neg_c[i] < TW'(mrpt_pkg::TORQUE_MIN)) begin
				sat_c[i] = mrpt_pkg::TORQUE_MIN;
			end else begin
				sat_c[i] = mrpt_pkg::TORQUE_W'(neg_c[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			trq_s9[i] <= sat_c[i];
		end
	end

	assign done            = vld_q[STAGES-1];
	assign result.torque_x = trq_s9[0];
	assign result.torque_y = trq_s9[1];
	assign result.torque_z = trq_s9[2];

	// every accepted word comes out with done high
	`MRPT_ASSERT_DLY(a_no_loss, start && !busy, 9, done, "accepted word did not complete")

	// no result word without an earlier accepted command
	`MRPT_ASSERT_IMP(a_no_invent, done, $past(start && !busy, 9), "done without a command")

	// a positive pre-negation sum must give a negative torque
	`MRPT_ASSERT_NXT(a_sign_x, vld_q[STAGES-2] && (t_c[0] > 0), result.torque_x[31],
		"torque x sign wrong after negation")

endmodule
